// ===== hw/rtl/page_frame_bitmap_allocator_macros.svh =====
// Assertion macros for the page frame bitmap allocator.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PFBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PFBA_ASSERT_NEVER(label, cond, msg) \
  `PFBA_ASSERT(label, !(cond), msg)
`else
`define PFBA_ASSERT(label, prop, msg)
`define PFBA_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== hw/rtl/pfba_pkg.sv =====
// Shared types and constants of the page frame bitmap allocator.
package pfba_pkg;
  localparam int PG_W       = 21;
  localparam int REQ_W      = 16;
  localparam int CFG_W      = 16;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_W     = 32;

  localparam logic [1:0] OP_FREE  = 2'd0;
  localparam logic [1:0] OP_USED  = 2'd1;
  localparam logic [1:0] OP_ALLOC = 2'd2;

  localparam logic CFG_PAGE_COUNT = 1'b0;
  localparam logic CFG_FLOOR      = 1'b1;

  typedef struct packed {
    logic [1:0]       op;
    logic [31:0]      range_begin;
    logic [31:0]      range_end;
    logic [REQ_W-1:0] page_request;
  } in_t;

  typedef struct packed {
    logic [31:0] alloc_address;
    logic        alloc_failed;
  } out_t;

  typedef struct packed {
    logic             found;
    logic             fail;
    logic [REQ_W-1:0] run;
    logic [PG_W-1:0]  start;
  } run_step_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_CLIP, ST_MARK_RD, ST_MARK_WR,
    ST_SCAN_RD, ST_SCAN_BITS, ST_RESP
  } state_e;
endpackage

// ===== hw/rtl/page_frame_bitmap_allocator.sv =====
// Page frame bitmap allocator: one free bit per 4 KiB page, first-fit allocation.
//
// Requests enter on in_valid_i/in_stall_o with payload in_data_i; each gives one
// result on out_valid_o/out_stall_i with payload out_data_o. Config registers
// (page count, allocation floor) are written through cfg_we_i/cfg_idx_i/cfg_data_i.
// One request is worked on at a time; in_stall_o is low only while idle.
// Mark ops pass through decode and clip, then a read and a write per bitmap word
// touched, then respond. Allocation scans 8 pages a cycle plus one memory read
// per 32-page word, from the floor to the end of the found run, then marks
// the run as above. The map RAM read port bounds both loops.
// After reset the map is cleared to all used, one word a cycle, with in_stall_o
// high; config writes are taken during that pass.
// A finished result sits in the output register; a stalling receiver holds it,
// and the next request is accepted meanwhile, finishing once the register frees.
`include "page_frame_bitmap_allocator_macros.svh"
module page_frame_bitmap_allocator #(
  parameter int MAX_PAGES = 32768
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  pfba_pkg::in_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output pfba_pkg::out_t           out_data_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [pfba_pkg::CFG_W-1:0] cfg_data_i
);
  import pfba_pkg::*;

  localparam int WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW    = $clog2(WORDS);
  localparam logic [AW-1:0]   LAST_WORD = AW'(WORDS - 1);
  localparam logic [PG_W-1:0] MAX_PG    = PG_W'(MAX_PAGES);
  localparam logic [32:0]     RND       = 33'((1 << PAGE_SHIFT) - 1);

  state_e state_q, state_d;
  logic [CFG_W-1:0] page_count_q, floor_q;
  in_t              req_q;
  logic [PG_W-1:0]  first_q, first_d, last_q, last_d, p_q, p_d, start_q, start_d;
  logic [REQ_W-1:0] run_q, run_d;
  logic             free_q, free_d;
  logic [AW-1:0]    w_q, w_d, lw_q, lw_d, clr_q, clr_d;
  logic [4:0]       lb_q, lb_d;
  out_t             res_q, res_d, out_q;
  logic             out_valid_q;
  logic             load_out;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  logic [PG_W-1:0]   size;
  logic [32:0]       beg_up, end_up;
  logic [PG_W-1:0]   lastc, lm1;
  logic [4:0]        lo_b, hi_b;
  logic [WORD_W-1:0] mask;
  run_step_t         step;

  assign size   = ({5'd0, page_count_q} > MAX_PG) ? MAX_PG : {5'd0, page_count_q};
  assign beg_up = {1'b0, req_q.range_begin} + RND;
  assign end_up = {1'b0, req_q.range_end} + RND;
  assign lastc  = (last_q > size) ? size : last_q;
  assign lm1    = lastc - 1'b1;
  assign lo_b   = (w_q == first_q[AW+4:5]) ? first_q[4:0] : 5'd0;
  assign hi_b   = (w_q == lw_q) ? lb_q : 5'd31;
  assign mask   = ({WORD_W{1'b1}} << lo_b) & ({WORD_W{1'b1}} >> (5'd31 - hi_b));

  pfba_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  pfba_run_finder u_finder (
    .base_i (p_q),
    .skip_i (p_q[2:0]),
    .bits_i (mem_rdata[{p_q[4:3], 3'b000} +: 8]),
    .size_i (size),
    .req_i  (req_q.page_request),
    .run_i  (run_q),
    .start_i(start_q),
    .step_o (step)
  );

  always_comb begin
    state_d   = state_q;
    first_d   = first_q;
    last_d    = last_q;
    p_d       = p_q;
    start_d   = start_q;
    run_d     = run_q;
    free_d    = free_q;
    w_d       = w_q;
    lw_d      = lw_q;
    lb_d      = lb_q;
    clr_d     = clr_q;
    res_d     = res_q;
    load_out  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = w_q;
    mem_raddr = w_q;
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_d = '{alloc_address: 32'd0, alloc_failed: 1'b0};
        case (req_q.op)
          OP_FREE: begin
            first_d = beg_up[32:12];
            last_d  = {1'b0, req_q.range_end[31:12]};
            free_d  = 1'b1;
            state_d = ST_CLIP;
          end
          OP_USED: begin
            first_d = {1'b0, req_q.range_begin[31:12]};
            last_d  = end_up[32:12];
            free_d  = 1'b0;
            state_d = ST_CLIP;
          end
          OP_ALLOC: begin
            if (req_q.page_request == '0) begin
              res_d.alloc_failed = 1'b1;
              state_d = ST_RESP;
            end else begin
              p_d     = {5'd0, floor_q};
              run_d   = '0;
              state_d = ST_SCAN_RD;
            end
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_CLIP: begin
        if (last_q <= first_q || first_q >= size) begin
          state_d = ST_RESP;
        end else begin
          w_d     = first_q[AW+4:5];
          lw_d    = lm1[AW+4:5];
          lb_d    = lm1[4:0];
          state_d = ST_MARK_RD;
        end
      end
      ST_MARK_RD: begin
        mem_re  = 1'b1;
        state_d = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        mem_we    = 1'b1;
        mem_wdata = free_q ? (mem_rdata | mask) : (mem_rdata & ~mask);
        w_d       = w_q + 1'b1;
        state_d   = (w_q == lw_q) ? ST_RESP : ST_MARK_RD;
      end
      ST_SCAN_RD: begin
        if (p_q >= size) begin
          res_d.alloc_failed = 1'b1;
          state_d = ST_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = p_q[AW+4:5];
          state_d   = ST_SCAN_BITS;
        end
      end
      ST_SCAN_BITS: begin
        run_d   = step.run;
        start_d = step.start;
        if (step.found) begin
          // mark the run used, then answer with its address
          res_d.alloc_address = {step.start[PG_W-2:0], 12'd0} & 32'hFFFF_FFFF;
          first_d = step.start;
          last_d  = step.start + PG_W'(req_q.page_request);
          free_d  = 1'b0;
          state_d = ST_CLIP;
        end else if (step.fail) begin
          res_d.alloc_failed = 1'b1;
          state_d = ST_RESP;
        end else begin
          p_d     = {p_q[PG_W-1:3] + 1'b1, 3'b000};
          state_d = (p_d[4:0] == 5'd0) ? ST_SCAN_RD : ST_SCAN_BITS;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      page_count_q <= CFG_W'(32768);
      floor_q      <= CFG_W'(256);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PAGE_COUNT: page_count_q <= cfg_data_i;
          CFG_FLOOR:      floor_q      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      req_q <= in_data_i;
    end
    if (load_out) begin
      out_q <= res_q;
    end
    first_q <= first_d;
    last_q  <= last_d;
    p_q     <= p_d;
    start_q <= start_d;
    run_q   <= run_d;
    free_q  <= free_d;
    w_q     <= w_d;
    lw_q    <= lw_d;
    lb_q    <= lb_d;
    res_q   <= res_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PFBA_ASSERT(a_clear_stalls, (state_q == ST_CLEAR) |-> in_stall_o, "request taken during clear")
  `PFBA_ASSERT_NEVER(a_scan_no_write, (state_q == ST_SCAN_RD || state_q == ST_SCAN_BITS) && mem_we, "map written during scan")
  `PFBA_ASSERT(a_fail_zero_addr, (out_valid_o && out_data_o.alloc_failed) |-> (out_data_o.alloc_address == 32'd0), "failed result with address")
  `PFBA_ASSERT(a_mark_in_range, (state_q == ST_MARK_WR) |-> (w_q <= lw_q), "mark ran past last word")
endmodule

// ===== hw/rtl/pfba_ram.sv =====
// Generic single-port-write, registered-read RAM.
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/pfba_run_finder.sv =====
// Eight-page step of the first-fit free run search.
module pfba_run_finder (
  input  logic [pfba_pkg::PG_W-1:0]  base_i,
  input  logic [2:0]                 skip_i,
  input  logic [7:0]                 bits_i,
  input  logic [pfba_pkg::PG_W-1:0]  size_i,
  input  logic [pfba_pkg::REQ_W-1:0] req_i,
  input  logic [pfba_pkg::REQ_W-1:0] run_i,
  input  logic [pfba_pkg::PG_W-1:0]  start_i,
  output pfba_pkg::run_step_t        step_o
);
  import pfba_pkg::*;

  always_comb begin
    logic            done;
    logic [PG_W-1:0] pg;
    done   = 1'b0;
    pg     = '0;
    step_o = '{found: 1'b0, fail: 1'b0, run: run_i, start: start_i};
    for (int k = 0; k < 8; k++) begin
      pg = {base_i[PG_W-1:3], 3'(k)};
      if (!done && (3'(k) >= skip_i)) begin
        if (pg >= size_i) begin
          step_o.fail = 1'b1;
          done        = 1'b1;
        end else if (bits_i[k]) begin
          if (step_o.run == '0) begin
            step_o.start = pg;
          end
          step_o.run = step_o.run + 1'b1;
          if (step_o.run == req_i) begin
            step_o.found = 1'b1;
            done         = 1'b1;
          end
        end else begin
          step_o.run = '0;
        end
      end
    end
  end
endmodule
